// File: rtl/slsc_pkg.sv
`timescale 1ns / 1ps

package slsc_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned StatusW     = 2;
  localparam logic [7:0]  MaxLenReset = 8'd99;

  localparam logic [7:0] ChCpmEof = 8'h1A;
  localparam logic [7:0] ChTilde  = 8'h7E;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  typedef enum logic [2:0] {
    PH_SKIP     = 3'd0,
    PH_BODY     = 3'd1,
    PH_COMMENT  = 3'd2,
    PH_AFTER_CR = 3'd3,
    PH_DRAIN    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ILLEGAL  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_EOD      = 2'd3
  } status_e;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_EOL  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_data;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   char_value;
    logic [ByteW-1:0]   char_pos;
    logic [ByteW-1:0]   line_length;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   error_pos;
  } result_t;

endpackage

// File: rtl/script_line_scanner_core.sv
`timescale 1ns / 1ps
// A word is accepted into the input register, then scanned into the result register
// once that is free; m_axis takes the result from there.
// Throughput: one word per cycle unless m_axis stalls; one scan step sits between them.
// A word that yields no result still takes one step and leaves the result register alone.
// Reset (rst_ni low, asynchronous): both registers empty, scanner skipping leading blanks,
// line counters cleared, max_len back to 99.
module script_line_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // end_of_data
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] char_value, [15:8] char_pos,
                                        // [23:16] line_length, [25:24] status,
                                        // [33:26] error_pos, [39:34] zero
  output logic        m_axis_tuser_o    // kind
);
  import slsc_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.in_byte     = s_axis_tdata_i;
  assign in_item.end_of_data = s_axis_tlast_i;
  assign step                = item_valid && out_free;

  slsc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (step),
    .item_o       (item)
  );

  slsc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  slsc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (out_res)
  );

  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tdata_o = {6'd0, out_res.error_pos, out_res.status, out_res.line_length,
                           out_res.char_pos, out_res.char_value};

endmodule

// File: rtl/slsc_in_stage.sv
`timescale 1ns / 1ps

module slsc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  slsc_pkg::item_t in_item_i,
  output logic           item_valid_o,
  input  logic           item_take_i,
  output slsc_pkg::item_t item_o
);
  import slsc_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: rtl/slsc_scan.sv
`timescale 1ns / 1ps

module slsc_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             step_i,
  input  slsc_pkg::item_t  item_i,
  output logic             res_valid_o,
  output slsc_pkg::result_t res_o
);
  import slsc_pkg::*;

  logic [7:0]   max_len_q;
  phase_e       phase_q, phase_d;
  logic [7:0]   stored_q, stored_d;
  logic [7:0]   trim_q, trim_d;
  logic [1:0]   err_q, err_d;
  logic [7:0]   bad_pos_q, bad_pos_d;

  logic [7:0]   b;
  logic         eod;
  logic         blank;
  logic         do_body;
  logic         do_eol;
  logic [1:0]   eol_status;
  logic         first_bad;

  assign b     = item_i.in_byte;
  assign eod   = item_i.end_of_data;
  assign blank = (b == ChSpace) || (b == ChTab);

  always_comb begin
    phase_d     = phase_q;
    stored_d    = stored_q;
    trim_d      = trim_q;
    err_d       = err_q;
    bad_pos_d   = bad_pos_q;
    do_body     = 1'b0;
    do_eol      = 1'b0;
    eol_status  = err_q;
    first_bad   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (phase_q == PH_DRAIN) begin
      if (eod) begin
        phase_d   = PH_SKIP;
        stored_d  = '0;
        trim_d    = '0;
        err_d     = ST_OK;
        bad_pos_d = '0;
      end
    end else if (eod) begin
      phase_d    = PH_SKIP;
      do_eol     = 1'b1;
      eol_status = ST_EOD;
    end else begin
      unique case (phase_q)
        PH_COMMENT: begin
          do_body = (b == ChCr) || (b == ChLf) || (b == ChCpmEof);
        end
        PH_AFTER_CR: begin
          phase_d = PH_SKIP;
          do_body = (b != ChLf) && !blank;
        end
        PH_BODY: begin
          do_body = 1'b1;
        end
        default: begin
          phase_d = PH_SKIP;
          do_body = !blank;
        end
      endcase
    end

    if (do_body) begin
      if (b == ChCr) begin
        phase_d = PH_AFTER_CR;
        do_eol  = 1'b1;
      end else if (b == ChLf) begin
        phase_d = PH_SKIP;
        do_eol  = 1'b1;
      end else if (b == ChCpmEof) begin
        phase_d    = PH_DRAIN;
        do_eol     = 1'b1;
        eol_status = ST_EOD;
      end else begin
        phase_d = PH_BODY;
        if (((b < ChSpace) || (b > ChTilde)) && (err_q == ST_OK)) begin
          first_bad = 1'b1;
          bad_pos_d = stored_q;
          err_d     = ST_ILLEGAL;
        end
        if (b == ChHash) begin
          phase_d = PH_COMMENT;
        end else if (stored_q >= max_len_q) begin
          err_d = ST_TOO_LONG;
        end else begin
          stored_d         = stored_q + 8'd1;
          if (!blank) begin
            trim_d = stored_q + 8'd1;
          end
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_CHAR;
          res_o.char_value = b;
          res_o.char_pos   = stored_q;
          res_o.status     = first_bad ? ST_ILLEGAL : ST_OK;
        end
      end
    end

    if (do_eol) begin
      res_valid_o       = 1'b1;
      res_o.kind        = KIND_EOL;
      res_o.line_length = trim_q;
      res_o.status      = eol_status;
      res_o.error_pos   = (eol_status == ST_ILLEGAL) ? bad_pos_q : 8'd0;
      stored_d          = '0;
      trim_d            = '0;
      err_d             = ST_OK;
      bad_pos_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SKIP;
      stored_q  <= '0;
      trim_q    <= '0;
      err_q     <= ST_OK;
      bad_pos_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      stored_q  <= stored_d;
      trim_q    <= trim_d;
      err_q     <= err_d;
      bad_pos_q <= bad_pos_d;
    end
  end

endmodule

// File: rtl/slsc_out_stage.sv
`timescale 1ns / 1ps

module slsc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  slsc_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slsc_pkg::result_t out_o
);
  import slsc_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import slsc_pkg::*;

  typedef struct packed {
    logic       cfg;
    logic       typed;
    logic       eod;
    logic [7:0] b;
    result_t    exp;
  } dir_row_t;

  localparam int unsigned NDir      = 25;
  localparam int unsigned RandWords = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  script_line_scanner_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // scanner copy
  phase_e     scan_phase;
  logic [7:0] line_limit;
  logic [7:0] stored_cnt;
  logic [7:0] trim_len;
  status_e    line_status;
  logic [7:0] bad_pos;

  result_t     scan_results_q [$];
  dir_row_t    dir_tab [NDir];
  result_t     got;
  result_t     want;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned line_ends_seen = 0;
  int unsigned words_sent = 0;
  int unsigned settings_used = 0;
  bit          no_idle = 1'b0;
  int unsigned ready_hold = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

  function automatic void reset_line();
    stored_cnt  = '0;
    trim_len    = '0;
    line_status = ST_OK;
    bad_pos     = '0;
  endfunction

  function automatic bit close_line(status_e st, output result_t r);
    r             = '0;
    r.kind        = KIND_EOL;
    r.line_length = trim_len;
    r.status      = st;
    r.error_pos   = (st == ST_ILLEGAL) ? bad_pos : 8'd0;
    reset_line();
    return 1'b1;
  endfunction

  function automatic bit take_body_byte(logic [7:0] b, output result_t r);
    bit first_bad;
    first_bad = 1'b0;
    r = '0;
    if (b == ChCr) begin
      scan_phase = PH_AFTER_CR;
      return close_line(line_status, r);
    end
    if (b == ChLf) begin
      scan_phase = PH_SKIP;
      return close_line(line_status, r);
    end
    if (b == ChCpmEof) begin
      scan_phase = PH_DRAIN;
      return close_line(ST_EOD, r);
    end
    scan_phase = PH_BODY;
    if ((b < ChSpace || b > ChTilde) && line_status == ST_OK) begin
      bad_pos     = stored_cnt;
      line_status = ST_ILLEGAL;
      first_bad   = 1'b1;
    end
    if (b == ChHash) begin
      scan_phase = PH_COMMENT;
      return 1'b0;
    end
    if (stored_cnt >= line_limit) begin
      line_status = ST_TOO_LONG;
      return 1'b0;
    end
    r.kind       = KIND_CHAR;
    r.char_value = b;
    r.char_pos   = stored_cnt;
    r.status     = first_bad ? ST_ILLEGAL : ST_OK;
    stored_cnt   = stored_cnt + 8'd1;
    if (b != ChSpace && b != ChTab) trim_len = stored_cnt;
    return 1'b1;
  endfunction

  function automatic bit scan_word(logic [7:0] b, logic eod, output result_t r);
    r = '0;
    if (scan_phase == PH_DRAIN) begin
      if (eod) begin
        scan_phase = PH_SKIP;
        reset_line();
      end
      return 1'b0;
    end
    if (eod) begin
      scan_phase = PH_SKIP;
      return close_line(ST_EOD, r);
    end
    case (scan_phase)
      PH_COMMENT: begin
        if (b == ChCr || b == ChLf || b == ChCpmEof) return take_body_byte(b, r);
        return 1'b0;
      end
      PH_AFTER_CR: begin
        scan_phase = PH_SKIP;
        if (b == ChLf || b == ChSpace || b == ChTab) return 1'b0;
        return take_body_byte(b, r);
      end
      PH_BODY: begin
        return take_body_byte(b, r);
      end
      default: begin
        scan_phase = PH_SKIP;
        if (b == ChSpace || b == ChTab) return 1'b0;
        return take_body_byte(b, r);
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic result_t res(kind_e k, logic [7:0] cv, logic [7:0] cp,
                                  logic [7:0] len, status_e st, logic [7:0] ep);
    result_t r;
    r.kind        = k;
    r.char_value  = cv;
    r.char_pos    = cp;
    r.line_length = len;
    r.status      = st;
    r.error_pos   = ep;
    return r;
  endfunction

  function automatic dir_row_t row(logic cfg, logic typed, logic eod, logic [7:0] b,
                                   result_t exp);
    dir_row_t d;
    d.cfg   = cfg;
    d.typed = typed;
    d.eod   = eod;
    d.b     = b;
    d.exp   = exp;
    return d;
  endfunction

  task automatic send_word(logic [7:0] b, logic eod, logic typed, result_t typed_res);
    result_t     r;
    bit          has;
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eod;
    do @(posedge clk_i); while (!s_axis_tready_o);
    has = scan_word(b, eod, r);
    if (typed) scan_results_q.push_back(typed_res);
    else if (has) scan_results_q.push_back(r);
    words_sent++;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    int unsigned n;
    n = 0;
    s_axis_tvalid_i <= 1'b0;
    while (scan_results_q.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_len(logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    line_limit = v;
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_blank();
    send_word($urandom_range(0, 1) ? ChSpace : ChTab, 1'b0, 1'b0, '0);
  endtask

  task automatic send_line();
    int unsigned sel;
    int unsigned len;
    int unsigned term;
    logic [7:0]  c;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      repeat ($urandom_range(1, 20))
        send_word(8'($urandom), $urandom_range(0, 15) == 0, 1'b0, '0);
    end else begin
      repeat ($urandom_range(0, 3)) send_blank();
      if (line_limit == 8'd255 && $urandom_range(0, 9) == 0) len = $urandom_range(250, 262);
      else len = $urandom_range(0, (line_limit < 20) ? line_limit + 3 : 24);
      repeat (len) begin
        sel = $urandom_range(0, 39);
        if (sel == 0) c = 8'($urandom_range(8'h7F, 8'hFF));
        else if (sel == 1) c = 8'($urandom_range(8'h00, 8'h1F));
        else if (sel < 6) c = ChSpace;
        else c = 8'($urandom_range(8'h21, 8'h7E));
        send_word(c, 1'b0, 1'b0, '0);
      end
      if ($urandom_range(0, 7) == 0) begin
        send_word(ChHash, 1'b0, 1'b0, '0);
        repeat ($urandom_range(0, 6))
          send_word(8'($urandom_range(8'h20, 8'hFF)), 1'b0, 1'b0, '0);
      end
      repeat ($urandom_range(0, 2)) send_blank();
      term = $urandom_range(0, 99);
      if (term < 40) begin
        send_word(ChLf, 1'b0, 1'b0, '0);
      end else if (term < 60) begin
        send_word(ChCr, 1'b0, 1'b0, '0);
      end else if (term < 85) begin
        send_word(ChCr, 1'b0, 1'b0, '0);
        send_word(ChLf, 1'b0, 1'b0, '0);
      end else if (term < 93) begin
        send_word(8'($urandom), 1'b1, 1'b0, '0);
      end else begin
        send_word(ChCpmEof, 1'b0, 1'b0, '0);
        repeat ($urandom_range(0, 4)) send_word(8'($urandom), 1'b0, 1'b0, '0);
        send_word(8'($urandom), 1'b1, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold      <= ready_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      ready_hold      <= pick_gap();
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind        = kind_e'(m_axis_tuser_o);
      got.char_value  = m_axis_tdata_o[7:0];
      got.char_pos    = m_axis_tdata_o[15:8];
      got.line_length = m_axis_tdata_o[23:16];
      got.status      = m_axis_tdata_o[25:24];
      got.error_pos   = m_axis_tdata_o[33:26];
      results_seen++;
      if (got.kind == KIND_EOL) line_ends_seen++;
      if (scan_results_q.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: unexpected word kind=%0d tdata=%h", m_axis_tuser_o, m_axis_tdata_o);
        mismatches++;
      end else begin
        want = scan_results_q.pop_front();
        if (got !== want || m_axis_tdata_o[39:34] !== 6'd0) begin
          if (mismatches < 10)
            $display("ERROR: word %0d exp kind=%0d chr=%h pos=%0d len=%0d st=%0d ep=%0d",
                     results_seen, want.kind, want.char_value, want.char_pos,
                     want.line_length, want.status, want.error_pos,
                     " | got kind=%0d chr=%h pos=%0d len=%0d st=%0d ep=%0d pad=%h",
                     got.kind, got.char_value, got.char_pos, got.line_length,
                     got.status, got.error_pos, m_axis_tdata_o[39:34]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned phase_no;
    logic [7:0]  v;
    dir_tab[0]  = row(1'b0, 1'b1, 1'b1, 8'h00, res(KIND_EOL, 8'd0, 8'd0, 8'd0, ST_EOD, 8'd0));
    dir_tab[1]  = row(1'b0, 1'b0, 1'b0, ChSpace, '0);
    dir_tab[2]  = row(1'b0, 1'b1, 1'b0, 8'h41, res(KIND_CHAR, 8'h41, 8'd0, 8'd0, ST_OK, 8'd0));
    dir_tab[3]  = row(1'b0, 1'b1, 1'b0, 8'h00,
                      res(KIND_CHAR, 8'h00, 8'd1, 8'd0, ST_ILLEGAL, 8'd0));
    dir_tab[4]  = row(1'b0, 1'b0, 1'b0, 8'hFF, '0);
    dir_tab[5]  = row(1'b0, 1'b0, 1'b0, ChTab, '0);
    dir_tab[6]  = row(1'b0, 1'b0, 1'b0, ChTilde, '0);
    dir_tab[7]  = row(1'b0, 1'b0, 1'b0, ChSpace, '0);
    dir_tab[8]  = row(1'b0, 1'b1, 1'b0, ChLf,
                      res(KIND_EOL, 8'd0, 8'd0, 8'd5, ST_ILLEGAL, 8'd1));
    dir_tab[9]  = row(1'b0, 1'b0, 1'b0, ChHash, '0);
    dir_tab[10] = row(1'b0, 1'b0, 1'b0, 8'h01, '0);
    dir_tab[11] = row(1'b0, 1'b1, 1'b0, ChCr, res(KIND_EOL, 8'd0, 8'd0, 8'd0, ST_OK, 8'd0));
    dir_tab[12] = row(1'b0, 1'b0, 1'b0, ChLf, '0);
    dir_tab[13] = row(1'b0, 1'b0, 1'b0, 8'h78, '0);
    dir_tab[14] = row(1'b0, 1'b0, 1'b0, ChCr, '0);
    dir_tab[15] = row(1'b0, 1'b1, 1'b1, 8'hFF, res(KIND_EOL, 8'd0, 8'd0, 8'd0, ST_EOD, 8'd0));
    dir_tab[16] = row(1'b0, 1'b0, 1'b0, ChTab, '0);
    dir_tab[17] = row(1'b0, 1'b0, 1'b0, 8'h42, '0);
    dir_tab[18] = row(1'b0, 1'b1, 1'b0, ChCpmEof,
                      res(KIND_EOL, 8'd0, 8'd0, 8'd1, ST_EOD, 8'd0));
    dir_tab[19] = row(1'b0, 1'b0, 1'b0, 8'h43, '0);
    dir_tab[20] = row(1'b0, 1'b0, 1'b1, 8'h00, '0);
    dir_tab[21] = row(1'b1, 1'b0, 1'b0, 8'd1, '0);
    dir_tab[22] = row(1'b0, 1'b0, 1'b0, 8'h61, '0);
    dir_tab[23] = row(1'b0, 1'b0, 1'b0, 8'h62, '0);
    dir_tab[24] = row(1'b0, 1'b1, 1'b0, ChLf,
                      res(KIND_EOL, 8'd0, 8'd0, 8'd1, ST_TOO_LONG, 8'd0));

    scan_phase = PH_SKIP;
    line_limit = MaxLenReset;
    reset_line();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NDir; i++) begin
      if (dir_tab[i].cfg) begin
        drain_results();
        write_max_len(dir_tab[i].b);
      end else begin
        send_word(dir_tab[i].b, dir_tab[i].eod, dir_tab[i].typed, dir_tab[i].exp);
      end
    end

    phase_no = 0;
    while (words_sent < RandWords + NDir) begin
      case (phase_no % 5)
        0:       v = 8'd1;
        1:       v = 8'd255;
        2:       v = MaxLenReset;
        3:       v = 8'($urandom_range(1, 255));
        default: v = 8'($urandom_range(1, 12));
      endcase
      drain_results();
      no_idle = (phase_no % 4 == 3);
      write_max_len(v);
      repeat (20) send_line();
      phase_no++;
    end

    drain_results();
    if (scan_results_q.size() != 0) begin
      $display("ERROR: %0d expected words never arrived", scan_results_q.size());
    end
    $display("Sent %0d words under %0d max_len settings, incl. 1 and 255.", words_sent,
             settings_used);
    $display("Checked %0d result words, %0d of them line ends; %0d mismatches.",
             results_seen, line_ends_seen, mismatches);
    if (mismatches == 0 && scan_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
